// ----- rtl/vgcs_pkg.sv -----
// Shared types and constants for the voxel grid curvature sampler.
// Holds the request/response structs, command, kind, status and register codes.
// No dependencies.
package vgcs_pkg;

    localparam int AXIS_BITS_DEF   = 5;
    localparam int INDEX_BITS_DEF  = 20;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam int SCORE_BITS = 32;
    localparam int KIND_BITS  = 2;
    localparam int CFG_BITS   = 24;
    localparam int CFG_IDX_W  = 2;
    localparam int ADDR_FW    = 15;
    localparam int VTX_FW     = 20;

    // Command codes
    localparam logic CMD_VERTEX = 1'b0;
    localparam logic CMD_READ   = 1'b1;

    // Work kinds handed from front to back
    localparam logic [KIND_BITS-1:0] KIND_UPDATE  = 2'd0;
    localparam logic [KIND_BITS-1:0] KIND_PRUNED  = 2'd1;
    localparam logic [KIND_BITS-1:0] KIND_OUTSIDE = 2'd2;
    localparam logic [KIND_BITS-1:0] KIND_READ    = 2'd3;

    // Result status codes
    localparam logic [2:0] ST_NEW      = 3'd0;
    localparam logic [2:0] ST_REPLACED = 3'd1;
    localparam logic [2:0] ST_KEPT     = 3'd2;
    localparam logic [2:0] ST_PRUNED   = 3'd3;
    localparam logic [2:0] ST_OUTSIDE  = 3'd4;
    localparam logic [2:0] ST_READ     = 3'd5;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Z = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_CELL = 2'd3;

    localparam logic [CFG_BITS-1:0] INV_CELL_RESET = 24'd65536;

    typedef struct packed {
        logic               cmd;
        logic [19:0]        vertex_index;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] pos_z;
        logic signed [15:0] curv_major;
        logic signed [15:0] curv_minor;
        logic [14:0]        read_cell;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [14:0] cell_addr;
        logic        cell_valid;
        logic [19:0] chosen_vertex;
    } rsp_t;

endpackage

// ----- rtl/vgcs_front.sv -----
// Front end: accepts transactions, holds the grid registers, tests pruning,
// maps positions to cells and pushes classified work into the queue.
// Depends on vgcs_pkg.
module vgcs_front
    import vgcs_pkg::*;
#(
    parameter int AXIS_BITS  = AXIS_BITS_DEF,
    parameter int INDEX_BITS = INDEX_BITS_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    hold,
    input  logic                    req_valid,
    output logic                    req_stall,
    input  req_t                    req,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_BITS-1:0]     cfg_data,
    output logic                    push,
    input  logic                    full,
    output logic [KIND_BITS-1:0]    kind,
    output logic [3*AXIS_BITS-1:0]  addr,
    output logic [INDEX_BITS-1:0]   vidx,
    output logic [SCORE_BITS-1:0]   score
);

    localparam int CELL_BITS = 3 * AXIS_BITS;
    localparam int PROD_BITS = 42;

    logic signed [15:0]     org_x_reg, org_y_reg, org_z_reg;
    logic [CFG_BITS-1:0]    inv_cell_reg;

    // stage 1: differences, magnitudes, prune test
    logic                   s1_valid_reg;
    logic                   s1_cmd_reg;
    logic                   s1_prune_reg;
    logic [INDEX_BITS-1:0]  s1_vidx_reg;
    logic [CELL_BITS-1:0]   s1_raddr_reg;
    logic signed [16:0]     s1_dx_reg, s1_dy_reg, s1_dz_reg;
    logic [15:0]            s1_amaj_reg, s1_amin_reg;

    // stage 2: products
    logic                   s2_valid_reg;
    logic                   s2_cmd_reg;
    logic                   s2_prune_reg;
    logic [INDEX_BITS-1:0]  s2_vidx_reg;
    logic [CELL_BITS-1:0]   s2_raddr_reg;
    logic signed [PROD_BITS-1:0] s2_px_reg, s2_py_reg, s2_pz_reg;
    logic [SCORE_BITS-1:0]  s2_score_reg;

    logic                   accept, s1_adv, s2_adv;
    logic [15:0]            amaj, amin;
    logic [17:0]            minor_x4, major_x3;
    logic [INDEX_BITS+VTX_FW-1:0]  vidx_ext;
    logic [CELL_BITS+ADDR_FW-1:0]  raddr_ext;
    logic signed [24:0]     inv_s;
    logic                   out_x, out_y, out_z;

    assign s2_adv    = s2_valid_reg && !full;
    assign s1_adv    = s1_valid_reg && (!s2_valid_reg || s2_adv);
    assign req_stall = hold || (s1_valid_reg && !s1_adv);
    assign accept    = req_valid && !req_stall;

    always_comb
    begin
        amaj      = req.curv_major[15] ? (~req.curv_major + 16'd1) : req.curv_major;
        amin      = req.curv_minor[15] ? (~req.curv_minor + 16'd1) : req.curv_minor;
        minor_x4  = {amin, 2'b00};
        major_x3  = {1'b0, amaj, 1'b0} + {2'b00, amaj};
        vidx_ext  = {{INDEX_BITS{1'b0}}, req.vertex_index};
        raddr_ext = {{CELL_BITS{1'b0}}, req.read_cell};
        inv_s     = $signed({1'b0, inv_cell_reg});
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            org_x_reg    <= '0;
            org_y_reg    <= '0;
            org_z_reg    <= '0;
            inv_cell_reg <= INV_CELL_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ORIGIN_X: org_x_reg    <= cfg_data[15:0];
                CFG_ORIGIN_Y: org_y_reg    <= cfg_data[15:0];
                CFG_ORIGIN_Z: org_z_reg    <= cfg_data[15:0];
                CFG_INV_CELL: inv_cell_reg <= cfg_data;
                default:      ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
                s1_valid_reg <= 1'b1;
            else if (s1_adv)
                s1_valid_reg <= 1'b0;
            if (s1_adv)
                s2_valid_reg <= 1'b1;
            else if (s2_adv)
                s2_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_cmd_reg   <= req.cmd;
            s1_prune_reg <= minor_x4 > major_x3;
            s1_vidx_reg  <= vidx_ext[INDEX_BITS-1:0];
            s1_raddr_reg <= raddr_ext[CELL_BITS-1:0];
            s1_dx_reg    <= {req.pos_x[15], req.pos_x} - {org_x_reg[15], org_x_reg};
            s1_dy_reg    <= {req.pos_y[15], req.pos_y} - {org_y_reg[15], org_y_reg};
            s1_dz_reg    <= {req.pos_z[15], req.pos_z} - {org_z_reg[15], org_z_reg};
            s1_amaj_reg  <= amaj;
            s1_amin_reg  <= amin;
        end
        if (s1_adv)
        begin
            s2_cmd_reg   <= s1_cmd_reg;
            s2_prune_reg <= s1_prune_reg;
            s2_vidx_reg  <= s1_vidx_reg;
            s2_raddr_reg <= s1_raddr_reg;
            s2_px_reg    <= s1_dx_reg * inv_s;
            s2_py_reg    <= s1_dy_reg * inv_s;
            s2_pz_reg    <= s1_dz_reg * inv_s;
            s2_score_reg <= {16'd0, s1_amaj_reg} * {16'd0, s1_amin_reg};
        end
    end

    // classify: a negative product or a cell past the grid edge is outside
    always_comb
    begin
        out_x = s2_px_reg[PROD_BITS-1] || (|s2_px_reg[PROD_BITS-1:16+AXIS_BITS]);
        out_y = s2_py_reg[PROD_BITS-1] || (|s2_py_reg[PROD_BITS-1:16+AXIS_BITS]);
        out_z = s2_pz_reg[PROD_BITS-1] || (|s2_pz_reg[PROD_BITS-1:16+AXIS_BITS]);
        if (s2_cmd_reg == CMD_READ)
            kind = KIND_READ;
        else if (s2_prune_reg)
            kind = KIND_PRUNED;
        else if (out_x || out_y || out_z)
            kind = KIND_OUTSIDE;
        else
            kind = KIND_UPDATE;
        if (s2_cmd_reg == CMD_READ)
            addr = s2_raddr_reg;
        else
            addr = {s2_px_reg[16+AXIS_BITS-1:16], s2_py_reg[16+AXIS_BITS-1:16],
                    s2_pz_reg[16+AXIS_BITS-1:16]};
    end

    assign push  = s2_adv;
    assign vidx  = s2_vidx_reg;
    assign score = s2_score_reg;

endmodule

// ----- rtl/vgcs_queue.sv -----
// Small register queue that decouples the front end from the cell store.
// Depends on vgcs_pkg for the default depth.
module vgcs_queue
    import vgcs_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             not_empty,
    output logic [WIDTH-1:0] head
);

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [PTR_BITS-1:0] LAST = PTR_BITS'(DEPTH - 1);

    logic [WIDTH-1:0]    slot_reg [DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, rd_ptr_reg, wr_ptr_next, rd_ptr_next;
    logic [PTR_BITS:0]   count_reg, count_next;

    assign full      = (count_reg == (PTR_BITS+1)'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

endmodule

// ----- rtl/vgcs_back.sv -----
// Back end: owns the cell store, clears it after reset, performs the
// read-compare-write per transaction with write forwarding, registers results.
// Depends on vgcs_pkg.
module vgcs_back
    import vgcs_pkg::*;
#(
    parameter int AXIS_BITS  = AXIS_BITS_DEF,
    parameter int INDEX_BITS = INDEX_BITS_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    output logic                    busy,
    input  logic                    q_not_empty,
    output logic                    q_pop,
    input  logic [KIND_BITS-1:0]    q_kind,
    input  logic [3*AXIS_BITS-1:0]  q_addr,
    input  logic [INDEX_BITS-1:0]   q_vidx,
    input  logic [SCORE_BITS-1:0]   q_score,
    output logic                    rsp_valid,
    input  logic                    rsp_stall,
    output rsp_t                    rsp
);

    localparam int CELL_BITS  = 3 * AXIS_BITS;
    localparam int CELLS      = 1 << CELL_BITS;
    localparam int ENTRY_BITS = 1 + INDEX_BITS + SCORE_BITS;

    logic [ENTRY_BITS-1:0]  cell_mem [CELLS];
    logic [ENTRY_BITS-1:0]  mem_q_reg;
    logic [CELL_BITS:0]     clr_cnt_reg;

    logic                   e_valid_reg;
    logic [KIND_BITS-1:0]   e_kind_reg;
    logic [CELL_BITS-1:0]   e_addr_reg;
    logic [INDEX_BITS-1:0]  e_vidx_reg;
    logic [SCORE_BITS-1:0]  e_score_reg;
    logic                   fwd_hit_reg;
    logic [ENTRY_BITS-1:0]  fwd_data_reg;

    logic                   rsp_valid_reg;
    rsp_t                   rsp_reg, rsp_next;

    logic                   e_adv, wr_en;
    logic [ENTRY_BITS-1:0]  cur, wr_data;
    logic                   cur_valid;
    logic [INDEX_BITS-1:0]  cur_idx;
    logic [SCORE_BITS-1:0]  cur_score;
    logic [CELL_BITS+ADDR_FW-1:0] addr_ext;
    logic [INDEX_BITS+VTX_FW-1:0] cur_ext, new_ext;

    assign busy  = !clr_cnt_reg[CELL_BITS];
    assign e_adv = e_valid_reg && (!rsp_valid_reg || !rsp_stall);
    assign q_pop = q_not_empty && !busy && (!e_valid_reg || e_adv);

    always_comb
    begin
        cur       = fwd_hit_reg ? fwd_data_reg : mem_q_reg;
        cur_valid = cur[ENTRY_BITS-1];
        cur_idx   = cur[SCORE_BITS +: INDEX_BITS];
        cur_score = cur[SCORE_BITS-1:0];
        addr_ext  = {{ADDR_FW{1'b0}}, e_addr_reg};
        cur_ext   = {{VTX_FW{1'b0}}, cur_idx};
        new_ext   = {{VTX_FW{1'b0}}, e_vidx_reg};
        wr_data   = {1'b1, e_vidx_reg, e_score_reg};
        wr_en     = 1'b0;
        rsp_next  = '0;
        case (e_kind_reg)
            KIND_READ:
            begin
                rsp_next.status     = ST_READ;
                rsp_next.cell_addr  = addr_ext[ADDR_FW-1:0];
                rsp_next.cell_valid = cur_valid;
                if (cur_valid)
                    rsp_next.chosen_vertex = cur_ext[VTX_FW-1:0];
            end
            KIND_PRUNED:  rsp_next.status = ST_PRUNED;
            KIND_OUTSIDE: rsp_next.status = ST_OUTSIDE;
            KIND_UPDATE:
            begin
                rsp_next.cell_addr  = addr_ext[ADDR_FW-1:0];
                rsp_next.cell_valid = 1'b1;
                if (!cur_valid || e_score_reg > cur_score)
                begin
                    rsp_next.status        = cur_valid ? ST_REPLACED : ST_NEW;
                    rsp_next.chosen_vertex = new_ext[VTX_FW-1:0];
                    wr_en                  = e_adv;
                end
                else
                begin
                    rsp_next.status        = ST_KEPT;
                    rsp_next.chosen_vertex = cur_ext[VTX_FW-1:0];
                end
            end
            default: rsp_next = '0;
        endcase
    end

    // cell store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (busy)
            cell_mem[clr_cnt_reg[CELL_BITS-1:0]] <= '0;
        else if (wr_en)
            cell_mem[e_addr_reg] <= wr_data;
        if (q_pop)
            mem_q_reg <= cell_mem[q_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg   <= '0;
            e_valid_reg   <= 1'b0;
            fwd_hit_reg   <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (busy)
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (q_pop)
            begin
                e_valid_reg <= 1'b1;
                // the store returns the old word when the cell is written this cycle
                fwd_hit_reg <= wr_en && (q_addr == e_addr_reg);
            end
            else if (e_adv)
                e_valid_reg <= 1'b0;
            if (e_adv)
                rsp_valid_reg <= 1'b1;
            else if (!rsp_stall)
                rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            e_kind_reg   <= q_kind;
            e_addr_reg   <= q_addr;
            e_vidx_reg   <= q_vidx;
            e_score_reg  <= q_score;
            fwd_data_reg <= wr_data;
        end
        if (e_adv)
            rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// ----- rtl/voxel_grid_curvature_sampler.sv -----
// Top level of the voxel grid curvature sampler.
// Instantiates vgcs_front, vgcs_queue and vgcs_back; depends on vgcs_pkg.
//
// The block sorts mesh vertices into a cube of 2^AXIS_BITS cells per axis and
// keeps, per cell, the vertex with the strictly largest |major*minor|; ties keep
// the earlier vertex. A vertex with 4|minor| > 3|major| is pruned before any cell
// is computed, and one whose cell lands outside the grid is flagged and not
// stored. A read transaction returns the contents of one cell. Every accepted
// transaction yields exactly one result, in order. After reset the cell store
// is cleared one entry per cycle, and req_stall stays high until that is done,
// while configuration writes are taken as usual. After that the block sustains
// one transaction per cycle while rsp_stall is low: the front end is a two-stage
// pipeline (subtract and prune test, then the three position multipliers), and
// the cell store does one read and one write per cycle with the write forwarded
// to an immediately following access of the same cell. A transaction passes
// the two front stages, the queue, the store read stage and the result
// register. A short queue between front and back lets each side stall on its
// own. Write configuration only while no transaction is outstanding.
module voxel_grid_curvature_sampler
    import vgcs_pkg::*;
#(
    parameter int AXIS_BITS   = AXIS_BITS_DEF,
    parameter int INDEX_BITS  = INDEX_BITS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_stall,
    input  req_t                 req,
    output logic                 rsp_valid,
    input  logic                 rsp_stall,
    output rsp_t                 rsp,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_BITS-1:0]  cfg_data
);

    localparam int CELL_BITS = 3 * AXIS_BITS;
    localparam int QW        = KIND_BITS + CELL_BITS + INDEX_BITS + SCORE_BITS;

    logic                   busy;
    logic                   push, full, pop, not_empty;
    logic [KIND_BITS-1:0]   f_kind;
    logic [CELL_BITS-1:0]   f_addr;
    logic [INDEX_BITS-1:0]  f_vidx;
    logic [SCORE_BITS-1:0]  f_score;
    logic [QW-1:0]          push_data, head;

    // Front end: hold off new transactions while the store is being cleared
    vgcs_front #(
        .AXIS_BITS  (AXIS_BITS),
        .INDEX_BITS (INDEX_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .hold      (busy),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push),
        .full      (full),
        .kind      (f_kind),
        .addr      (f_addr),
        .vidx      (f_vidx),
        .score     (f_score)
    );

    // Pack classified work for the queue
    assign push_data = {f_kind, f_addr, f_vidx, f_score};

    vgcs_queue #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .not_empty (not_empty),
        .head      (head)
    );

    // Back end: cell store update and registered result
    vgcs_back #(
        .AXIS_BITS  (AXIS_BITS),
        .INDEX_BITS (INDEX_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .busy        (busy),
        .q_not_empty (not_empty),
        .q_pop       (pop),
        .q_kind      (head[QW-1 -: KIND_BITS]),
        .q_addr      (head[INDEX_BITS+SCORE_BITS +: CELL_BITS]),
        .q_vidx      (head[SCORE_BITS +: INDEX_BITS]),
        .q_score     (head[SCORE_BITS-1:0]),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .rsp         (rsp)
    );

endmodule
